### rtl/cubic_stereo_resampler_defines.svh
// Assertion macros for the cubic stereo resampler checker.
// Each macro expands to one clocked assertion on clk with arst_n as the disable.
`ifndef CUBIC_STEREO_RESAMPLER_DEFINES_SVH
`define CUBIC_STEREO_RESAMPLER_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define CSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define CSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/csr_pkg.sv
// Shared constants, types and the cubic coefficient table of the resampler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package csr_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int FRAC_BITS     = 12;
	localparam int MAX_OUT       = 12;
	localparam int WINDOW        = 4;

	localparam int SAMPLE_W   = 16;
	localparam int PERIOD_W   = 17;
	localparam int PHASE_W    = 18;
	localparam int OUT_W      = 17;
	localparam int COUNT_W    = $clog2(MAX_OUT + 1);
	localparam int FILL_W     = $clog2(WINDOW);
	localparam int K_W        = $clog2(WINDOW);
	localparam int KCNT_W     = $clog2(WINDOW + 1);
	localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_PERIOD = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_STEP   = 1'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd16000;
	localparam logic [PERIOD_W-1:0] STEP_RESET   = 17'd16000;

	localparam logic [FILL_W-1:0] FILL_DONE = FILL_W'(WINDOW - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Coefficient table and weight interpolation.
	localparam int COEF_W  = 17;
	localparam int W_W     = COEF_W + 1;
	localparam int WP_W    = W_W + FRAC_BITS + 1;
	localparam int POS_W   = FRAC_BITS + $clog2(TABLE_ENTRIES);
	localparam int IDXR_W  = POS_W - FRAC_BITS;
	localparam int ROW_W   = $clog2(TABLE_ENTRIES + 1);
	localparam longint TE3 = longint'(TABLE_ENTRIES) * TABLE_ENTRIES * TABLE_ENTRIES;
	localparam longint HALF_FRAC = longint'(1) << (FRAC_BITS - 1);

	// Dot product and final scaling by 1/32767.
	localparam int PR_W          = SAMPLE_W + W_W;
	localparam int ACC_W         = PR_W + 2;
	localparam int OUT_DEN_SHIFT = 15;
	localparam longint OUT_DEN   = (longint'(1) << OUT_DEN_SHIFT) - 1;
	localparam longint OUT_HALF  = OUT_DEN / 2;
	localparam int Q0_W          = ACC_W - OUT_DEN_SHIFT;
	localparam int R_W           = Q0_W + 1;
	localparam int Q2_W          = R_W - OUT_DEN_SHIFT;
	localparam int R2_W          = OUT_DEN_SHIFT + 1;
	localparam int Q_W           = Q0_W + 1;
	localparam longint OUT_POS_MAX = 65535;
	localparam longint OUT_NEG_MAG = 65536;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	typedef struct packed {
		frame_t [WINDOW-1:0] taps;
	} job_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
		logic                    last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MAC,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_PUSH,
		ST_END
	} back_state_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [WINDOW-1:0] coef_row_t;
	typedef coef_row_t [TABLE_ENTRIES:0] coef_tab_t;

	// Row i holds 0.5*[1 t t^2 t^3]M at t = i/TABLE_ENTRIES in Q1.15.
	function automatic coef_t coef_at(int row, int k);
		longint n;
		longint i;
		longint num;
		longint mag;
		longint q;
		n = TABLE_ENTRIES;
		i = row;
		case (k)
			0: num = -i * n * n + 2 * i * i * n - i * i * i;
			1: num = 2 * n * n * n - 5 * i * i * n + 3 * i * i * i;
			2: num = i * n * n + 4 * i * i * n - 3 * i * i * i;
			default: num = -i * i * n + i * i * i;
		endcase
		num = num * 16384;
		mag = (num < 0) ? -num : num;
		q = (mag + TE3 / 2) / TE3;
		return coef_t'((num < 0) ? -q : q);
	endfunction

	function automatic coef_tab_t build_coef_rom();
		coef_tab_t t;
		for (int i = 0; i <= TABLE_ENTRIES; i++) begin
			for (int k = 0; k < WINDOW; k++) begin
				t[i][k] = coef_at(i, k);
			end
		end
		return t;
	endfunction

	localparam coef_tab_t COEF_ROM = build_coef_rom();

	// The most negative code is treated as -32767 so a sample never drops below -1.
	function automatic logic signed [SAMPLE_W-1:0] tap_value(logic signed [SAMPLE_W-1:0] x);
		logic signed [SAMPLE_W-1:0] min_code;
		min_code = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		return (x == min_code) ? (min_code + SAMPLE_W'(1)) : x;
	endfunction

endpackage

### rtl/cubic_stereo_resampler.sv
// Top level of the Catmull-Rom cubic stereo resampler.
// Holds the two timing registers and connects csr_front, csr_jobq and csr_back (csr_pkg).
//
// Source frames are pushed in and resampled stereo values are popped out, both through
// queue-style handshakes. The first three frames after reset only fill the tap window
// and produce nothing; each later frame produces up to twelve results, the final one
// marked with last_of_run. A frame is taken when pushed while the two-entry job
// queue has room. Each result passes through the back end in order: a check, the
// bit-serial phase/period divider, the four-tap weight and product pipeline, the
// scaling and saturation steps and a push that waits while the result queue is full;
// each frame adds a job pop, a final check and an end step. Timing registers must be
// written only while the block holds no work; the block itself does not enforce this.
`timescale 1ns / 1ps

module cubic_stereo_resampler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [csr_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic signed [csr_pkg::SAMPLE_W-1:0]   right_sample,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [csr_pkg::OUT_W-1:0]      left_out,
	output logic signed [csr_pkg::OUT_W-1:0]      right_out,
	output logic                                  last_of_run,
	input  logic                                  cfg_write,
	input  logic [csr_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [csr_pkg::CFG_DATA_W-1:0]        cfg_data
);

	logic [csr_pkg::PERIOD_W-1:0] period_q;
	logic [csr_pkg::PERIOD_W-1:0] step_q;
	logic                         job_full;
	logic                         job_push;
	logic                         job_valid;
	logic                         job_pop;
	csr_pkg::job_t                job_in;
	csr_pkg::job_t                job_out;
	csr_pkg::result_t             result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= csr_pkg::PERIOD_RESET;
			step_q   <= csr_pkg::STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_addr)
				csr_pkg::REG_SOURCE_PERIOD: period_q <= cfg_data[csr_pkg::PERIOD_W-1:0];
				csr_pkg::REG_OUTPUT_STEP:   step_q   <= cfg_data[csr_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	csr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.job_full     (job_full),
		.job_push     (job_push),
		.job          (job_in)
	);

	csr_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.valid  (job_valid),
		.pop    (job_pop),
		.dout   (job_out)
	);

	csr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.job_pop   (job_pop),
		.period    (period_q),
		.step      (step_q),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	assign left_out    = result.left;
	assign right_out   = result.right;
	assign last_of_run = result.last;

endmodule

### rtl/csr_front.sv
// Front end: takes source frames, keeps the four-frame window and classifies frames.
// Frames that arrive once the fill is done send a window snapshot to the job queue. Uses csr_pkg.
`timescale 1ns / 1ps

module csr_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [csr_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic signed [csr_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic                                  job_full,
	output logic                                  job_push,
	output csr_pkg::job_t                         job
);

	csr_pkg::frame_t [csr_pkg::WINDOW-1:0] window_q;
	logic [csr_pkg::FILL_W-1:0]            fill_q;
	csr_pkg::frame_t [csr_pkg::WINDOW-1:0] window_next;
	logic                                  accept;

	assign full   = job_full;
	assign accept = push && !job_full;

	always_comb begin
		for (int i = 0; i < csr_pkg::WINDOW - 1; i++) begin
			window_next[i] = window_q[i + 1];
		end
		window_next[csr_pkg::WINDOW-1].left  = left_sample;
		window_next[csr_pkg::WINDOW-1].right = right_sample;
	end

	assign job_push = accept && (fill_q == csr_pkg::FILL_DONE);
	assign job.taps = window_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && (fill_q != csr_pkg::FILL_DONE)) begin
			fill_q <= fill_q + csr_pkg::FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= window_next;
		end
	end

endmodule

### rtl/csr_jobq.sv
// Two-entry queue of window snapshots between the front end and the back end.
// Uses csr_pkg for the job type and depth.
`timescale 1ns / 1ps

module csr_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  csr_pkg::job_t din,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output csr_pkg::job_t dout
);

	csr_pkg::job_t                  mem_q [csr_pkg::QUEUE_DEPTH];
	logic [csr_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [csr_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [csr_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (cnt_q == csr_pkg::QCNT_W'(csr_pkg::QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + csr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + csr_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + csr_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - csr_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

### rtl/csr_div.sv
// Restoring divider that forms the phase fraction floor(phase * 2^FRAC_BITS / period).
// One quotient bit per cycle; the dividend must be below the divisor. Uses csr_pkg.
`timescale 1ns / 1ps

module csr_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [csr_pkg::PERIOD_W-1:0]      dividend,
	input  logic [csr_pkg::PERIOD_W-1:0]      divisor,
	output logic                              done,
	output logic [csr_pkg::FRAC_BITS-1:0]     quotient
);

	logic                              active_q;
	logic [csr_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [csr_pkg::PERIOD_W-1:0]      rem_q;
	logic [csr_pkg::FRAC_BITS-1:0]     quo_q;
	logic [csr_pkg::PERIOD_W:0]        shifted;
	logic [csr_pkg::PERIOD_W:0]        rem_next;
	logic                              fits;

	assign shifted  = {rem_q, 1'b0};
	assign fits     = (shifted >= {1'b0, divisor});
	assign rem_next = fits ? (shifted - {1'b0, divisor}) : shifted;
	assign done     = active_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			cnt_q    <= csr_pkg::DIV_CNT_W'(csr_pkg::FRAC_BITS);
		end else if (active_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - csr_pkg::DIV_CNT_W'(1);
			end else begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
		end else if (active_q && (cnt_q != '0)) begin
			rem_q <= rem_next[csr_pkg::PERIOD_W-1:0];
			quo_q <= {quo_q[csr_pkg::FRAC_BITS-2:0], fits};
		end
	end

endmodule

### rtl/csr_back.sv
// Back end: owns the output phase, runs the divider, the cubic dot product and the
// final scaling, and holds finished results in a two-entry queue. Uses csr_pkg, csr_div.
`timescale 1ns / 1ps

module csr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	input  csr_pkg::job_t                     job,
	output logic                              job_pop,
	input  logic [csr_pkg::PERIOD_W-1:0]      period,
	input  logic [csr_pkg::PERIOD_W-1:0]      step,
	input  logic                              pop,
	output logic                              empty,
	output csr_pkg::result_t                  result
);

	csr_pkg::back_state_t state_q, state_d;

	csr_pkg::frame_t [csr_pkg::WINDOW-1:0] taps_q;
	logic [csr_pkg::PHASE_W-1:0]           phase_q;
	logic [csr_pkg::COUNT_W-1:0]           count_q;
	logic [csr_pkg::ROW_W-1:0]             idx_q;
	logic [csr_pkg::FRAC_BITS-1:0]         frem_q;
	logic [csr_pkg::KCNT_W-1:0]            kcnt_q;

	logic                                  v_s1, v_s2, v_s3;
	logic [csr_pkg::K_W-1:0]               k_s1, k_s2, k_s3;
	logic signed [csr_pkg::WP_W-1:0]       wprod_s1;
	logic signed [csr_pkg::W_W-1:0]        c0_s1;
	logic signed [csr_pkg::W_W-1:0]        w_s2;
	logic signed [csr_pkg::PR_W-1:0]       prod_s3 [2];

	logic signed [csr_pkg::ACC_W-1:0]      acc_q [2];
	logic [csr_pkg::ACC_W-1:0]             n_q [2];
	logic                                  neg_q [2];
	logic [csr_pkg::Q0_W-1:0]              q0_q [2];
	logic [csr_pkg::R_W-1:0]               r_q [2];
	logic signed [csr_pkg::OUT_W-1:0]      res_q [2];

	csr_pkg::result_t                      oq_mem_q [csr_pkg::QUEUE_DEPTH];
	logic [csr_pkg::QPTR_W-1:0]            oq_wr_q;
	logic [csr_pkg::QPTR_W-1:0]            oq_rd_q;
	logic [csr_pkg::QCNT_W-1:0]            oq_cnt_q;
	logic                                  oq_full;
	logic                                  oq_pop;

	logic                                  run_more;
	logic                                  div_start;
	logic                                  div_done;
	logic [csr_pkg::FRAC_BITS-1:0]         div_quo;
	logic                                  frac_load;
	logic                                  mac_issue;
	logic                                  mac_done;
	logic                                  fin1_en, fin2_en, fin3_en;
	logic                                  oq_push;
	logic                                  phase_end;
	logic [csr_pkg::PHASE_W-1:0]           period_ext;
	logic [csr_pkg::PHASE_W-1:0]           phase_step;
	logic                                  last_flag;

	logic [csr_pkg::POS_W-1:0]             pos;
	logic [csr_pkg::IDXR_W-1:0]            idx_raw;
	logic [csr_pkg::ROW_W-1:0]             idx_clamped;
	csr_pkg::coef_t                        c0_rd, c1_rd;
	logic signed [csr_pkg::W_W-1:0]        d_w;
	logic signed [csr_pkg::WP_W-1:0]       d_ext, r_ext, wprod;
	logic [csr_pkg::WP_W-1:0]              wmag, wrnd;
	logic signed [csr_pkg::WP_W-1:0]       wsum;
	logic signed [csr_pkg::PR_W-1:0]       tap_ext [2];
	logic signed [csr_pkg::PR_W-1:0]       w_ext;
	logic [csr_pkg::ACC_W-1:0]             n_d [2];
	logic [csr_pkg::Q0_W-1:0]              q0_d [2];
	logic [csr_pkg::R_W-1:0]               r_d [2];
	logic signed [csr_pkg::OUT_W-1:0]      res_d [2];

	csr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (phase_q[csr_pkg::PERIOD_W-1:0]),
		.divisor  (period),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign period_ext = {1'b0, period};
	assign phase_step = phase_q + {1'b0, step};
	assign run_more   = (count_q < csr_pkg::COUNT_W'(csr_pkg::MAX_OUT)) && (phase_q < period_ext);
	assign last_flag  = (count_q == csr_pkg::COUNT_W'(csr_pkg::MAX_OUT - 1)) ||
		(phase_step >= period_ext);
	assign mac_done   = v_s3 && (k_s3 == csr_pkg::K_W'(csr_pkg::WINDOW - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			csr_pkg::ST_IDLE: begin
				if (job_valid) state_d = csr_pkg::ST_CHECK;
			end
			csr_pkg::ST_CHECK: begin
				state_d = run_more ? csr_pkg::ST_DIV : csr_pkg::ST_END;
			end
			csr_pkg::ST_DIV: begin
				if (div_done) state_d = csr_pkg::ST_MAC;
			end
			csr_pkg::ST_MAC: begin
				if (mac_done) state_d = csr_pkg::ST_FIN1;
			end
			csr_pkg::ST_FIN1: state_d = csr_pkg::ST_FIN2;
			csr_pkg::ST_FIN2: state_d = csr_pkg::ST_FIN3;
			csr_pkg::ST_FIN3: state_d = csr_pkg::ST_PUSH;
			csr_pkg::ST_PUSH: begin
				if (!oq_full) state_d = csr_pkg::ST_CHECK;
			end
			csr_pkg::ST_END: state_d = csr_pkg::ST_IDLE;
			default: state_d = csr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		frac_load = 1'b0;
		mac_issue = 1'b0;
		fin1_en   = 1'b0;
		fin2_en   = 1'b0;
		fin3_en   = 1'b0;
		oq_push   = 1'b0;
		phase_end = 1'b0;
		case (state_q)
			csr_pkg::ST_IDLE:  job_pop   = job_valid;
			csr_pkg::ST_CHECK: div_start = run_more;
			csr_pkg::ST_DIV:   frac_load = div_done;
			csr_pkg::ST_MAC:   mac_issue = (kcnt_q < csr_pkg::KCNT_W'(csr_pkg::WINDOW));
			csr_pkg::ST_FIN1:  fin1_en   = 1'b1;
			csr_pkg::ST_FIN2:  fin2_en   = 1'b1;
			csr_pkg::ST_FIN3:  fin3_en   = 1'b1;
			csr_pkg::ST_PUSH:  oq_push   = !oq_full;
			csr_pkg::ST_END:   phase_end = 1'b1;
			default: ;
		endcase
	end

	// Table row and interpolation remainder from the phase fraction.
	always_comb begin
		pos     = csr_pkg::POS_W'(div_quo) * csr_pkg::POS_W'(csr_pkg::TABLE_ENTRIES);
		idx_raw = pos[csr_pkg::POS_W-1:csr_pkg::FRAC_BITS];
		if (idx_raw > csr_pkg::IDXR_W'(csr_pkg::TABLE_ENTRIES - 1)) begin
			idx_clamped = csr_pkg::ROW_W'(csr_pkg::TABLE_ENTRIES - 1);
		end else begin
			idx_clamped = csr_pkg::ROW_W'(idx_raw);
		end
	end

	// Weight pipeline: delta product, rounding, then the two tap products.
	always_comb begin
		c0_rd = csr_pkg::COEF_ROM[idx_q][kcnt_q[csr_pkg::K_W-1:0]];
		c1_rd = csr_pkg::COEF_ROM[idx_q + csr_pkg::ROW_W'(1)][kcnt_q[csr_pkg::K_W-1:0]];
		d_w   = csr_pkg::W_W'(c1_rd) - csr_pkg::W_W'(c0_rd);
		d_ext = csr_pkg::WP_W'(d_w);
		r_ext = signed'(csr_pkg::WP_W'(frem_q));
		wprod = d_ext * r_ext;

		wmag = wprod_s1[csr_pkg::WP_W-1] ? csr_pkg::WP_W'(-wprod_s1) : wprod_s1;
		wrnd = (wmag + csr_pkg::WP_W'(csr_pkg::HALF_FRAC)) >> csr_pkg::FRAC_BITS;
		wsum = csr_pkg::WP_W'(c0_s1) +
			(wprod_s1[csr_pkg::WP_W-1] ? -signed'(wrnd) : signed'(wrnd));

		tap_ext[0] = csr_pkg::PR_W'(csr_pkg::tap_value(taps_q[k_s2].left));
		tap_ext[1] = csr_pkg::PR_W'(csr_pkg::tap_value(taps_q[k_s2].right));
		w_ext      = csr_pkg::PR_W'(w_s2);
	end

	// Rounded division of the sums by 32767, done as folds of 2^15 - 1.
	always_comb begin
		logic [csr_pkg::ACC_W-1:0]  mag;
		logic [csr_pkg::Q2_W-1:0]   q2;
		logic [csr_pkg::R2_W-1:0]   r2;
		logic [csr_pkg::Q_W-1:0]    q;
		logic [csr_pkg::Q_W-1:0]    negq;
		for (int ch = 0; ch < 2; ch++) begin
			mag = acc_q[ch][csr_pkg::ACC_W-1] ? csr_pkg::ACC_W'(-acc_q[ch]) : acc_q[ch];
			n_d[ch] = mag + csr_pkg::ACC_W'(csr_pkg::OUT_HALF);

			q0_d[ch] = n_q[ch][csr_pkg::ACC_W-1:csr_pkg::OUT_DEN_SHIFT];
			r_d[ch]  = csr_pkg::R_W'(n_q[ch][csr_pkg::OUT_DEN_SHIFT-1:0]) +
				csr_pkg::R_W'(q0_d[ch]);

			q2 = r_q[ch][csr_pkg::R_W-1:csr_pkg::OUT_DEN_SHIFT];
			r2 = csr_pkg::R2_W'(r_q[ch][csr_pkg::OUT_DEN_SHIFT-1:0]) + csr_pkg::R2_W'(q2);
			q  = csr_pkg::Q_W'(q0_q[ch]) + csr_pkg::Q_W'(q2) +
				csr_pkg::Q_W'(r2 >= csr_pkg::R2_W'(csr_pkg::OUT_DEN));
			negq = -q;
			if (neg_q[ch]) begin
				if (q > csr_pkg::Q_W'(csr_pkg::OUT_NEG_MAG)) begin
					res_d[ch] = csr_pkg::OUT_W'(-csr_pkg::OUT_NEG_MAG);
				end else begin
					res_d[ch] = negq[csr_pkg::OUT_W-1:0];
				end
			end else if (q > csr_pkg::Q_W'(csr_pkg::OUT_POS_MAX)) begin
				res_d[ch] = csr_pkg::OUT_W'(csr_pkg::OUT_POS_MAX);
			end else begin
				res_d[ch] = q[csr_pkg::OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csr_pkg::ST_IDLE;
			phase_q <= '0;
			count_q <= '0;
			kcnt_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= mac_issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (job_pop) begin
				count_q <= '0;
			end else if (oq_push) begin
				count_q <= count_q + csr_pkg::COUNT_W'(1);
			end
			if (frac_load) begin
				kcnt_q <= '0;
			end else if (mac_issue) begin
				kcnt_q <= kcnt_q + csr_pkg::KCNT_W'(1);
			end
			if (oq_push) begin
				phase_q <= phase_step;
			end else if (phase_end) begin
				phase_q <= (phase_q >= period_ext) ? (phase_q - period_ext) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			taps_q <= job.taps;
		end
		if (frac_load) begin
			idx_q  <= idx_clamped;
			frem_q <= pos[csr_pkg::FRAC_BITS-1:0];
		end
		wprod_s1 <= wprod;
		c0_s1    <= csr_pkg::W_W'(c0_rd);
		k_s1     <= kcnt_q[csr_pkg::K_W-1:0];
		w_s2     <= wsum[csr_pkg::W_W-1:0];
		k_s2     <= k_s1;
		k_s3     <= k_s2;
		for (int ch = 0; ch < 2; ch++) begin
			prod_s3[ch] <= tap_ext[ch] * w_ext;
			if (frac_load) begin
				acc_q[ch] <= '0;
			end else if (v_s3) begin
				acc_q[ch] <= acc_q[ch] + csr_pkg::ACC_W'(prod_s3[ch]);
			end
			if (fin1_en) begin
				n_q[ch]   <= n_d[ch];
				neg_q[ch] <= acc_q[ch][csr_pkg::ACC_W-1];
			end
			if (fin2_en) begin
				q0_q[ch] <= q0_d[ch];
				r_q[ch]  <= r_d[ch];
			end
			if (fin3_en) begin
				res_q[ch] <= res_d[ch];
			end
		end
	end

	// Result queue.
	assign oq_full = (oq_cnt_q == csr_pkg::QCNT_W'(csr_pkg::QUEUE_DEPTH));
	assign empty   = (oq_cnt_q == '0);
	assign oq_pop  = pop && !empty;
	assign result  = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + csr_pkg::QPTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + csr_pkg::QPTR_W'(1);
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + csr_pkg::QCNT_W'(1);
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - csr_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q].left  <= res_q[0];
			oq_mem_q[oq_wr_q].right <= res_q[1];
			oq_mem_q[oq_wr_q].last  <= last_flag;
		end
	end

endmodule

### rtl/csr_checker.sv
// Port-level checker for the resampler, attached to the top level by a bind.
// Depends on csr_pkg and the assertion macros in cubic_stereo_resampler_defines.svh.
`timescale 1ns / 1ps
`include "cubic_stereo_resampler_defines.svh"

module csr_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic                                  full,
	input  logic                                  empty,
	input  logic                                  pop,
	input  logic signed [csr_pkg::OUT_W-1:0]      left_out,
	input  logic signed [csr_pkg::OUT_W-1:0]      right_out,
	input  logic                                  last_of_run
);

	logic [csr_pkg::KCNT_W-1:0]  seen_q;
	logic [csr_pkg::COUNT_W-1:0] run_len_q;
	logic                        in_txn;
	logic                        out_txn;
	logic                        waiting;
	logic                        window_full;
	logic                        cap_reached;
	logic [2*csr_pkg::OUT_W:0]   out_word;

	assign in_txn      = push && !full;
	assign out_txn     = pop && !empty;
	assign waiting     = !empty && !pop;
	assign window_full = (seen_q == csr_pkg::KCNT_W'(csr_pkg::WINDOW));
	assign cap_reached = out_txn && (run_len_q == csr_pkg::COUNT_W'(csr_pkg::MAX_OUT - 1));
	assign out_word    = {left_out, right_out, last_of_run};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			run_len_q <= '0;
		end else begin
			if (in_txn && (seen_q != csr_pkg::KCNT_W'(csr_pkg::WINDOW))) begin
				seen_q <= seen_q + csr_pkg::KCNT_W'(1);
			end
			if (out_txn) begin
				run_len_q <= last_of_run ? '0 : (run_len_q + csr_pkg::COUNT_W'(1));
			end
		end
	end

	`CSR_ASSERT_NEXT(a_result_hold, waiting, !empty && $stable(out_word), "waiting result changed")
	`CSR_ASSERT_NOW(a_fill_first, !empty, window_full, "result offered before the window filled")
	`CSR_ASSERT_NOW(a_run_cap, cap_reached, last_of_run, "run of results exceeded the cap")

endmodule

bind cubic_stereo_resampler csr_checker u_checker (.*);
